[src/umr_pkg.sv]
// ----------------------------------------------------------------------------
// umr_pkg: shared types for the UART message receiver
// Result status codes and the event record from the framer to the emitter.
// ----------------------------------------------------------------------------
package umr_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BYTE = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } umr_status_t;

  // One event per accepted line sample
  typedef struct packed {
    logic        valid;   // sample processed this cycle
    logic        drain;   // message complete: deliver stored bytes
    umr_status_t status;  // status of the single result when not draining
  } umr_event_t;

  localparam int unsigned CfgWidth = 5;

endpackage

[src/umr_ram.sv]
// ----------------------------------------------------------------------------
// umr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module umr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/umr_frame.sv]
// ----------------------------------------------------------------------------
// umr_frame: 8N1 framer
// Shifts data bits in one per sample, checks start/stop, counts bytes and
// writes each finished byte into the message store.
// ----------------------------------------------------------------------------
module umr_frame #(
  parameter int STORE_DEPTH = 16,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           rx_bit,
  input  logic [umr_pkg::CfgWidth-1:0]   message_limit,
  output umr_pkg::umr_event_t            ev,
  output logic [CW-1:0]                  byte_count,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [7:0]                     wr_data
);

  import umr_pkg::*;

  localparam int LW = (CW > CfgWidth) ? CW : CfgWidth;

  typedef enum logic [1:0] {
    M_IDLE,
    M_GAP,
    M_DATA,
    M_STOP
  } mode_t;

  mode_t        mode_r, mode_nxt;
  logic [7:0]   shift_r, shift_nxt;
  logic [2:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] lim_ext, lim_eff;
  logic [CW-1:0] start_count;

  assign lim_ext = LW'(message_limit);
  assign lim_eff = (lim_ext > LW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : lim_ext;

  // Idle start bit restarts the count at zero
  assign start_count = (mode_r == M_IDLE) ? '0 : count_r;

  assign byte_count = count_r;
  assign wr_addr    = count_r[AW-1:0];
  assign wr_data    = shift_r;

  always_comb begin
    mode_nxt    = mode_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    count_nxt   = count_r;
    ev.valid    = step;
    ev.drain    = 1'b0;
    ev.status   = ST_OK;
    wr_en       = 1'b0;
    if (step) begin
      unique case (mode_r)
        M_IDLE, M_GAP: begin
          if (rx_bit) begin
            // line high after a stop bit ends the message
            mode_nxt = M_IDLE;
            ev.drain = (mode_r == M_GAP) && (count_r != '0);
          end else begin
            bit_cnt_nxt = '0;
            count_nxt   = start_count;
            if (LW'(start_count) >= lim_eff) begin
              mode_nxt  = M_IDLE;
              ev.status = ST_FULL;
            end else begin
              mode_nxt  = M_DATA;
              shift_nxt = '0;
            end
          end
        end
        M_DATA: begin
          shift_nxt   = {rx_bit, shift_r[7:1]};
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            mode_nxt = M_STOP;
          end
        end
        M_STOP: begin
          if (rx_bit) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            mode_nxt  = M_GAP;
          end else begin
            mode_nxt  = M_IDLE;
            ev.status = ST_BAD;
          end
        end
        default: mode_nxt = M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      bit_cnt_r <= '0;
      count_r   <= '0;
    end else begin
      mode_r    <= mode_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      count_r   <= count_nxt;
    end
    shift_r <= shift_nxt;
  end

endmodule

[src/umr_emit.sv]
// ----------------------------------------------------------------------------
// umr_emit: result sequencer
// Registers single results and walks the message store on completion.
// ----------------------------------------------------------------------------
module umr_emit #(
  parameter int STORE_DEPTH = 16,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  umr_pkg::umr_event_t  ev,
  input  logic [CW-1:0]        byte_count,
  output logic                 ready,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output umr_pkg::umr_status_t out_status,
  output logic [7:0]           out_byte,
  output logic [3:0]           out_pos,
  output logic                 out_last
);

  import umr_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_LOAD,
    E_HOLD
  } estate_t;

  estate_t       state_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] total_r;
  logic          valid_r;
  umr_status_t   status_r;
  logic [7:0]    byte_r;
  logic [3:0]    pos_r;
  logic          last_r;
  logic          taken;

  assign taken      = valid_r && out_ready;
  assign ready      = (state_r == E_IDLE) && !valid_r;
  assign rd_en      = (state_r == E_READ);
  assign rd_addr    = idx_r;
  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_byte   = byte_r;
  assign out_pos    = pos_r;
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        E_IDLE: begin
          if (taken) begin
            valid_r <= 1'b0;
          end
          if (ev.valid) begin
            if (ev.drain) begin
              idx_r   <= '0;
              total_r <= byte_count;
              state_r <= E_READ;
            end else begin
              valid_r  <= 1'b1;
              status_r <= ev.status;
              byte_r   <= '0;
              pos_r    <= '0;
              last_r   <= 1'b1;
            end
          end
        end
        E_READ: state_r <= E_LOAD;
        E_LOAD: begin
          valid_r  <= 1'b1;
          status_r <= ST_BYTE;
          byte_r   <= rd_data;
          pos_r    <= 4'(idx_r);
          last_r   <= (CW'(idx_r) + CW'(1) == total_r);
          state_r  <= E_HOLD;
        end
        E_HOLD: begin
          if (taken) begin
            valid_r <= 1'b0;
            if (last_r) begin
              state_r <= E_IDLE;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= E_READ;
            end
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

endmodule

[src/uart_message_receiver.sv]
// ----------------------------------------------------------------------------
// uart_message_receiver: 8N1 serial message receiver
// Gathers back-to-back bytes into a message and delivers them in order.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  in_      slave      tdata[0] rx_bit (one line sample per bit period)
//  out_     master     tuser status, tdata {byte_position, data_byte}, tlast
//  cfg_     write      cfg_wdata message_limit
//
//  Timing: a sample that yields one result is accepted and the result appears
//  in the output register in the cycle after; the next sample is taken once that
//  result is transferred. Each byte of a completed message goes through a store
//  read, a load and a transfer before the next byte is read.
//  Reset: synchronous, active low; message_limit returns to 16.
//  Stalls: out_tready low holds the result and keeps in_tready low.
//
module uart_message_receiver #(
  parameter int STORE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] rx_bit, [7:1] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [11:8] byte_position, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata   // message_limit
);

  import umr_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [CfgWidth-1:0] limit_r;
  logic                step;
  umr_event_t          ev;
  logic [CW-1:0]       byte_count;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  umr_status_t         status;
  logic [7:0]          data_byte;
  logic [3:0]          byte_position;

  // message limit register; values above the store depth clamp in the framer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CfgWidth'(16);
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // one sample per transfer
  assign step = in_tvalid && in_tready;

  umr_frame #(.STORE_DEPTH(STORE_DEPTH)) u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_bit        (in_tdata[0]),
    .message_limit (limit_r),
    .ev            (ev),
    .byte_count    (byte_count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // message store
  umr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  umr_emit #(.STORE_DEPTH(STORE_DEPTH)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev         (ev),
    .byte_count (byte_count),
    .ready      (in_tready),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_byte   (data_byte),
    .out_pos    (byte_position),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'b0000, byte_position, data_byte};
  assign out_tuser = status;

endmodule

[sim/umr_checker.sv]
// ----------------------------------------------------------------------------
// umr_checker: result checker for the UART message receiver
// Watches the sample, result and register ports, keeps its own copy of the
// receiver state, predicts every result and compares them in order.
// ----------------------------------------------------------------------------
module umr_checker #(
  parameter int STORE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [0] rx_bit
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [15:0]                  out_tdata,  // [7:0] data_byte, [11:8] byte_position
  input  logic [1:0]                   out_tuser,  // [1:0] status
  input  logic                         out_tlast,
  input  logic                         cfg_we,
  input  logic [umr_pkg::CfgWidth-1:0] cfg_wdata,
  output int unsigned                  pending,
  output int unsigned                  fail_count
);

  import umr_pkg::*;

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_GAP  = 2'd1,
    RX_DATA = 2'd2,
    RX_STOP = 2'd3
  } rx_mode_t;

  typedef struct packed {
    umr_status_t status;
    logic [7:0]  data;
    logic [3:0]  pos;
    logic        last;
  } umr_result_t;

  rx_mode_t            rx_mode;
  logic [7:0]          bit_sel;
  logic [4:0]          bytes_held;
  logic [7:0]          msg_buf [STORE_DEPTH];
  logic [CfgWidth-1:0] limit_reg;
  umr_result_t         expected_results[$];
  umr_result_t         want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void add_result(umr_status_t s, logic [7:0] d, logic [3:0] p,
                                     logic l);
    umr_result_t r;
    r.status = s;
    r.data   = d;
    r.pos    = p;
    r.last   = l;
    expected_results.push_back(r);
  endfunction

  // One line sample in, its results queued
  task automatic predict_sample(input logic level);
    int unsigned eff;
    int unsigned i;
    logic        begin_byte;
    eff        = (limit_reg > STORE_DEPTH) ? STORE_DEPTH : limit_reg;
    begin_byte = 1'b0;
    case (rx_mode)
      RX_IDLE: begin
        if (level) add_result(ST_OK, 8'h00, 4'h0, 1'b1);
        else begin
          bytes_held = '0;
          begin_byte = 1'b1;
        end
      end
      RX_GAP: begin
        if (level) begin
          // message complete: hand out every stored byte
          for (i = 0; i < bytes_held && i < STORE_DEPTH; i++)
            add_result(ST_BYTE, msg_buf[i], 4'(i),
                       (i + 1 == bytes_held) || (i + 1 == STORE_DEPTH));
          if (bytes_held == 0) add_result(ST_OK, 8'h00, 4'h0, 1'b1);
          rx_mode = RX_IDLE;
        end else begin
          begin_byte = 1'b1;
        end
      end
      RX_DATA: begin
        if (level && bytes_held < STORE_DEPTH) msg_buf[bytes_held] |= bit_sel;
        bit_sel = bit_sel << 1;
        if (bit_sel == 8'h00) rx_mode = RX_STOP;
        add_result(ST_OK, 8'h00, 4'h0, 1'b1);
      end
      default: begin
        if (level) begin
          bytes_held++;
          rx_mode = RX_GAP;
          add_result(ST_OK, 8'h00, 4'h0, 1'b1);
        end else begin
          rx_mode = RX_IDLE;
          add_result(ST_BAD, 8'h00, 4'h0, 1'b1);
        end
      end
    endcase
    if (begin_byte) begin
      bit_sel = 8'h01;
      if (bytes_held >= eff) begin
        rx_mode = RX_IDLE;
        add_result(ST_FULL, 8'h00, 4'h0, 1'b1);
      end else begin
        rx_mode = RX_DATA;
        msg_buf[bytes_held] = 8'h00;
        add_result(ST_OK, 8'h00, 4'h0, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_mode    = RX_IDLE;
      bit_sel    = 8'h01;
      bytes_held = '0;
      limit_reg  = CfgWidth'(16);
      expected_results.delete();
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      // results first: a result never stems from a sample taken at the same edge
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result: tuser %h tdata %h tlast %b",
                           out_tuser, out_tdata, out_tlast));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            report($sformatf("status %h, want %0d", out_tuser, want.status));
          if (out_tdata[7:0] !== want.data)
            report($sformatf("data_byte %h, want %h", out_tdata[7:0], want.data));
          if (out_tdata[11:8] !== want.pos)
            report($sformatf("byte_position %h, want %h", out_tdata[11:8], want.pos));
          if (out_tlast !== want.last)
            report($sformatf("last %b, want %b", out_tlast, want.last));
          if (out_tdata[15:12] !== 4'h0)
            report($sformatf("tdata padding %h not zero", out_tdata[15:12]));
        end
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata[0]);
    end
    pending <= expected_results.size();
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the UART message receiver
// Drives 8N1 line samples (messages, bad stop bits, buffer overruns and line
// noise) under several message limits with random gaps and back-pressure;
// the checker beside the receiver predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import umr_pkg::*;

  localparam int STORE_DEPTH   = 16;
  localparam int WatchdogLimit = 2000;  // cycles with no transfer on either side
  localparam int PhaseItems    = 25;    // line samples per random phase

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;    // [0] rx_bit, [7:1] zero
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;   // [7:0] data_byte, [11:8] byte_position, [15:12] zero
  logic [1:0]          out_tuser;   // [1:0] status
  logic                out_tlast;   // last
  logic                cfg_we;
  logic [CfgWidth-1:0] cfg_wdata;   // message_limit

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned samples_sent;
  logic        idle_on;             // random gaps and stalls enabled

  uart_message_receiver #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  umr_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // 10-unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: ready drops in roughly 18% of cycles while idling
  // is on, and stays high otherwise.
  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 18);
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // One line sample. Valid stays high from one sample to the next unless a
  // gap is taken, so it is never lowered and raised in the same step.
  task automatic send_sample(input logic level);
    if (idle_on && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // 8N1 frame: start low, data LSB first, stop bit as given
  task automatic send_frame(input logic [7:0] value, input logic stop_level);
    int i;
    send_sample(1'b0);
    for (i = 0; i < 8; i++) send_sample(value[i]);
    send_sample(stop_level);
  endtask

  // n back-to-back frames; a good message is closed by a high slot, a broken
  // one ends on a low stop bit in its final frame
  task automatic send_message(input int unsigned n, input logic broken);
    int unsigned k;
    for (k = 0; k < n; k++)
      send_frame(8'($urandom_range(255)), !(broken && k + 1 == n));
    if (!broken) send_sample(1'b1);
  endtask

  // Lower valid and wait until every predicted result has gone out; every
  // sample yields a result, so the extra wait after that covers the output register.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CfgWidth-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_limits[6];
    int unsigned eff;
    int unsigned n;
    int unsigned pick;
    int unsigned phase_end;
    int          p;

    phase_limits = '{0, 1, 31, 16, 7, 0};
    phase_limits[5] = $urandom_range(2, 15);

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    samples_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle line, an all-ones byte delivered as a one-byte message,
    // then an all-zeros byte with a bad stop bit.
    send_sample(1'b1);
    send_frame(8'hFF, 1'b1);
    send_sample(1'b1);
    send_frame(8'h00, 1'b0);

    // Limit lowered mid-message: three bytes held, limit drops to two, the
    // next start bit must report buffer full.
    write_limit(CfgWidth'(16));
    send_frame(8'hA5, 1'b1);
    send_frame(8'h5A, 1'b1);
    send_frame(8'h3C, 1'b1);
    write_limit(CfgWidth'(2));
    send_sample(1'b0);

    // Random phases over several limits, zero and above the store depth
    // among them; the limit-16 phase runs with no gaps or stalls at all.
    for (p = 0; p < 6; p++) begin
      write_limit(CfgWidth'(phase_limits[p]));
      idle_on = (phase_limits[p] != 16);
      eff = (phase_limits[p] > STORE_DEPTH) ? STORE_DEPTH : phase_limits[p];
      // one message past the store depth: a full message, then overrun
      if (phase_limits[p] > STORE_DEPTH) send_message(STORE_DEPTH + 1, 1'b0);
      phase_end = samples_sent + PhaseItems;
      while (samples_sent < phase_end) begin
        pick = $urandom_range(99);
        n = ($urandom_range(7) == 0) ? $urandom_range(0, eff + 1) : $urandom_range(1, 3);
        if (pick < 70) begin
          send_message(n, 1'b0);
        end else if (pick < 82) begin
          send_message((n == 0) ? 1 : n, 1'b1);
        end else begin
          // line noise
          repeat ($urandom_range(1, 8)) send_sample($urandom_range(1));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
